// ----- rtl/core/multi_slot_oneshot_timer_top_defines.svh -----
// Assertion macros for the multi-slot one-shot timer.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef MULTI_SLOT_ONESHOT_TIMER_TOP_DEFINES_SVH
`define MULTI_SLOT_ONESHOT_TIMER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MSOT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msot: assertion failed");

// next-cycle implication
`define MSOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msot: assertion failed");

`else

`define MSOT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MSOT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/msot_pkg.sv -----
// Shared types and constants for the multi-slot one-shot timer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package msot_pkg;

    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int PERIOD_W = 32;
    localparam int EV_W     = 2;

    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = 32'd10;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_START = 2'd2,
        MODE_STOP  = 2'd3
    } mode_t;

    typedef enum logic [EV_W-1:0] {
        EV_DONE    = 2'd0,
        EV_EXPIRED = 2'd1,
        EV_IDLE    = 2'd2
    } event_t;

    typedef struct packed {
        logic shift;
        logic set_period;
        logic start;
        logic stop;
    } cell_cmd_t;

endpackage

// ----- rtl/core/msot_cell.sv -----
// One timer slot of the ring: armed flag, start time and period.
// Depends on msot_pkg.
`timescale 1ns / 1ps

module msot_cell #(
    parameter int TICK_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  msot_pkg::cell_cmd_t             cmd,
    input  logic [TICK_BITS-1:0]            now,
    input  logic [msot_pkg::PERIOD_W-1:0]   wr_period,
    input  logic                            nb_armed,
    input  logic [TICK_BITS-1:0]            nb_start,
    input  logic [msot_pkg::PERIOD_W-1:0]   nb_period,
    output logic                            armed,
    output logic [TICK_BITS-1:0]            start_time,
    output logic [msot_pkg::PERIOD_W-1:0]   period_val
);

    logic                          armed_reg, armed_next;
    logic [TICK_BITS-1:0]          start_reg, start_next;
    logic [msot_pkg::PERIOD_W-1:0] period_reg, period_next;

    always_comb
    begin
        armed_next  = armed_reg;
        start_next  = start_reg;
        period_next = period_reg;
        if (cmd.shift)
        begin
            armed_next  = nb_armed;
            start_next  = nb_start;
            period_next = nb_period;
        end
        else if (cmd.set_period)
        begin
            armed_next  = 1'b0;
            start_next  = now;
            period_next = wr_period;
        end
        else if (cmd.start)
        begin
            armed_next = 1'b1;
            start_next = now;
        end
        else if (cmd.stop)
        begin
            armed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg  <= 1'b0;
            start_reg  <= '0;
            period_reg <= '0;
        end
        else
        begin
            armed_reg  <= armed_next;
            start_reg  <= start_next;
            period_reg <= period_next;
        end
    end

    assign armed      = armed_reg;
    assign start_time = start_reg;
    assign period_val = period_reg;

endmodule

// ----- rtl/core/msot_head_eval.sv -----
// Expiry check for the slot at the head of the ring; builds the entry fed to the tail.
// Depends on msot_pkg.
`timescale 1ns / 1ps

module msot_head_eval #(
    parameter int TICK_BITS = 32
) (
    input  logic [TICK_BITS-1:0]            now,
    input  logic                            armed,
    input  logic [TICK_BITS-1:0]            start_time,
    input  logic [msot_pkg::PERIOD_W-1:0]   period_val,
    output logic                            expire,
    output logic                            nx_armed,
    output logic [TICK_BITS-1:0]            nx_start
);

    localparam int CMP_W = (TICK_BITS > msot_pkg::PERIOD_W) ? TICK_BITS : msot_pkg::PERIOD_W;

    logic [TICK_BITS-1:0] elapsed;

    // modular elapsed time
    assign elapsed  = now - start_time;
    assign expire   = armed && (CMP_W'(elapsed) >= CMP_W'(period_val));
    assign nx_armed = armed && !expire;
    assign nx_start = expire ? now : start_time;

endmodule

// ----- rtl/core/multi_slot_oneshot_timer_top.sv -----
// Top level of the multi-slot one-shot timer: ring of slot cells plus scan control.
// Depends on msot_pkg, msot_cell, msot_head_eval and the assertion macro header.
`timescale 1ns / 1ps
`include "multi_slot_oneshot_timer_top_defines.svh"

// Usage:
//   Input channel (in_valid/in_ready) carries one operation per transaction: tick,
//   set period, start or stop, addressed by slot. The user must write min_period
//   through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
//   Output channel (out_valid/out_ready) carries results: event_res,
//   expired_slot and last, with last set on the final result of a transaction.
//   Set period, start and stop act at acceptance and give one result the next
//   cycle; with a ready receiver they are taken one per cycle. A tick rotates
//   the slot ring through the head checker one slot per cycle unless a stall
//   freezes it; after the last slot a final state emits the final result and
//   the block returns to idle before the next transaction is taken. Expired
//   slots come out in ascending order; one result is held back so that last
//   can be marked on the final one.
//   One transaction is in flight at a time; in_ready is high when the block
//   is idle and the output register is empty or being drained.
//   A stalled receiver holds the output register and, when a second result
//   is due, freezes the ring until out_ready returns.
//   Reset clears all slots (disarmed, zero period and start), the tick
//   counter, and sets min_period to 10.
module multi_slot_oneshot_timer_top #(
    parameter int NUM_SLOTS = 16,
    parameter int TICK_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [msot_pkg::PERIOD_W-1:0]   cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [msot_pkg::MODE_W-1:0]     mode,
    input  logic [msot_pkg::SLOT_W-1:0]     slot,
    input  logic [msot_pkg::PERIOD_W-1:0]   period,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [msot_pkg::EV_W-1:0]       event_res,
    output logic [msot_pkg::SLOT_W-1:0]     expired_slot,
    output logic                            last
);

    localparam int CNT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FINAL = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [TICK_BITS-1:0]            now_reg, now_next;
    logic [msot_pkg::PERIOD_W-1:0]   min_period_reg, min_period_next;
    logic [CNT_W-1:0]                scan_cnt_reg, scan_cnt_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [msot_pkg::SLOT_W-1:0]     pend_slot_reg, pend_slot_next;
    logic                            out_valid_reg, out_valid_next;
    logic [msot_pkg::EV_W-1:0]       event_res_reg, event_res_next;
    logic [msot_pkg::SLOT_W-1:0]     expired_slot_reg, expired_slot_next;
    logic                            last_reg, last_next;

    logic                            in_accept;
    logic                            op_accept;
    logic                            out_free;
    logic                            stall;
    logic                            scan_step;
    logic [msot_pkg::PERIOD_W-1:0]   wr_period;

    logic                            cell_armed  [NUM_SLOTS];
    logic [TICK_BITS-1:0]            cell_start  [NUM_SLOTS];
    logic [msot_pkg::PERIOD_W-1:0]   cell_period [NUM_SLOTS];

    logic                            head_expire;
    logic                            tail_armed;
    logic [TICK_BITS-1:0]            tail_start;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_accept = in_valid && in_ready;
    assign op_accept = in_accept && (mode != msot_pkg::MODE_TICK);
    assign stall     = head_expire && pend_valid_reg && !out_free;
    assign scan_step = (state_reg == ST_SCAN) && !stall;
    assign wr_period = (period < min_period_reg) ? min_period_reg : period;

    msot_head_eval #(
        .TICK_BITS (TICK_BITS)
    ) u_head_eval (
        .now        (now_reg),
        .armed      (cell_armed[0]),
        .start_time (cell_start[0]),
        .period_val (cell_period[0]),
        .expire     (head_expire),
        .nx_armed   (tail_armed),
        .nx_start   (tail_start)
    );

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        msot_pkg::cell_cmd_t             cmd;
        logic                            hit;
        logic                            nb_armed;
        logic [TICK_BITS-1:0]            nb_start;
        logic [msot_pkg::PERIOD_W-1:0]   nb_period;

        assign hit            = ({{(32 - msot_pkg::SLOT_W){1'b0}}, slot} == 32'(i));
        assign cmd.shift      = scan_step;
        assign cmd.set_period = op_accept && hit && (mode == msot_pkg::MODE_SET);
        assign cmd.start      = op_accept && hit && (mode == msot_pkg::MODE_START);
        assign cmd.stop       = op_accept && hit && (mode == msot_pkg::MODE_STOP);

        if (i == NUM_SLOTS - 1)
        begin : g_tail
            assign nb_armed  = tail_armed;
            assign nb_start  = tail_start;
            assign nb_period = cell_period[0];
        end
        else
        begin : g_link
            assign nb_armed  = cell_armed[i+1];
            assign nb_start  = cell_start[i+1];
            assign nb_period = cell_period[i+1];
        end

        msot_cell #(
            .TICK_BITS (TICK_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .now        (now_reg),
            .wr_period  (wr_period),
            .nb_armed   (nb_armed),
            .nb_start   (nb_start),
            .nb_period  (nb_period),
            .armed      (cell_armed[i]),
            .start_time (cell_start[i]),
            .period_val (cell_period[i])
        );
    end

    always_comb
    begin
        state_next        = state_reg;
        now_next          = now_reg;
        min_period_next   = cfg_wr_en ? cfg_wr_data : min_period_reg;
        scan_cnt_next     = scan_cnt_reg;
        pend_valid_next   = pend_valid_reg;
        pend_slot_next    = pend_slot_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        event_res_next    = event_res_reg;
        expired_slot_next = expired_slot_reg;
        last_next         = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (mode == msot_pkg::MODE_TICK)
                    begin
                        now_next      = now_reg + 1'b1;
                        scan_cnt_next = '0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        out_valid_next    = 1'b1;
                        event_res_next    = msot_pkg::EV_DONE;
                        expired_slot_next = '0;
                        last_next         = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_step)
                begin
                    if (head_expire)
                    begin
                        // flush the held result, keep the new one back
                        if (pend_valid_reg)
                        begin
                            out_valid_next    = 1'b1;
                            event_res_next    = msot_pkg::EV_EXPIRED;
                            expired_slot_next = pend_slot_reg;
                            last_next         = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = msot_pkg::SLOT_W'(scan_cnt_reg);
                    end
                    if (scan_cnt_reg == CNT_W'(NUM_SLOTS - 1))
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        scan_cnt_next = scan_cnt_reg + 1'b1;
                    end
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    last_next         = 1'b1;
                    pend_valid_next   = 1'b0;
                    state_next        = ST_IDLE;
                    if (pend_valid_reg)
                    begin
                        event_res_next    = msot_pkg::EV_EXPIRED;
                        expired_slot_next = pend_slot_reg;
                    end
                    else
                    begin
                        event_res_next    = msot_pkg::EV_IDLE;
                        expired_slot_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            min_period_reg <= msot_pkg::MIN_PERIOD_RST;
            scan_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            min_period_reg <= min_period_next;
            scan_cnt_reg   <= scan_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg    <= pend_slot_next;
        event_res_reg    <= event_res_next;
        expired_slot_reg <= expired_slot_next;
        last_reg         <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = event_res_reg;
    assign expired_slot = expired_slot_reg;
    assign last         = last_reg;

    `MSOT_ASSERT_IMPL(a_ready_only_idle, clk, rst_n, in_ready, state_reg == ST_IDLE)
    `MSOT_ASSERT_IMPL(a_idle_no_pending, clk, rst_n, state_reg == ST_IDLE, !pend_valid_reg)
    `MSOT_ASSERT_IMPL(a_slot_zero_unless_expired, clk, rst_n,
        out_valid_reg && (event_res_reg != msot_pkg::EV_EXPIRED), expired_slot_reg == '0)
    `MSOT_ASSERT_NEXT(a_ring_frozen_on_stall, clk, rst_n,
        (state_reg == ST_SCAN) && stall, $stable(scan_cnt_reg) && (state_reg == ST_SCAN))
    `MSOT_ASSERT_IMPL(a_no_expiry_is_last, clk, rst_n,
        out_valid_reg && (event_res_reg != msot_pkg::EV_EXPIRED), last_reg)

endmodule

// ----- tb/msot_checker.sv -----
// Scoreboard for the multi-slot one-shot timer: watches both channels and the config port,
// predicts every result transaction and compares it field by field.
// Depends on msot_pkg.
`timescale 1ns / 1ps

module msot_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [msot_pkg::PERIOD_W-1:0] cfg_wr_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [msot_pkg::MODE_W-1:0]   mode,
    input  logic [msot_pkg::SLOT_W-1:0]   slot,
    input  logic [msot_pkg::PERIOD_W-1:0] period,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [msot_pkg::EV_W-1:0]     event_res,
    input  logic [msot_pkg::SLOT_W-1:0]   expired_slot,
    input  logic                          last,
    output int                            mismatches,
    output int                            pending_cnt
);

    localparam int SLOTS = 16;

    typedef struct packed {
        msot_pkg::event_t              ev;
        logic [msot_pkg::SLOT_W-1:0]   slot;
        logic                          last;
    } timer_result_t;

    timer_result_t                   due_results[$];
    int                              fail_cnt = 0;
    int                              due_cnt = 0;

    logic [msot_pkg::PERIOD_W-1:0]   min_period_q;
    logic [31:0]                     tick_count;
    logic [31:0]                     slot_start [SLOTS];
    logic [msot_pkg::PERIOD_W-1:0]   slot_period [SLOTS];
    logic [SLOTS-1:0]                slot_armed;

    assign mismatches  = fail_cnt;
    assign pending_cnt = due_cnt;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        fail_cnt++;
    endtask

    task automatic push_result(input msot_pkg::event_t ev,
                               input logic [msot_pkg::SLOT_W-1:0] s, input logic lst);
        timer_result_t r;
        r.ev   = ev;
        r.slot = s;
        r.last = lst;
        due_results.push_back(r);
    endtask

    task automatic apply_timer_op(input msot_pkg::mode_t m,
                                  input logic [msot_pkg::SLOT_W-1:0] s,
                                  input logic [msot_pkg::PERIOD_W-1:0] p);
        logic [31:0]      elapsed;
        logic [SLOTS-1:0] hit;
        int               n_hit;
        int               n_seen;
        int               i;
        hit    = '0;
        n_hit  = 0;
        n_seen = 0;
        case (m)
            msot_pkg::MODE_TICK:
            begin
                tick_count = tick_count + 32'd1;
                for (i = 0; i < SLOTS; i++)
                begin
                    elapsed = tick_count - slot_start[i];
                    if (slot_armed[i] && elapsed >= slot_period[i])
                    begin
                        slot_armed[i] = 1'b0;
                        slot_start[i] = tick_count;
                        hit[i]        = 1'b1;
                        n_hit++;
                    end
                end
                if (n_hit == 0)
                    push_result(msot_pkg::EV_IDLE, '0, 1'b1);
                else
                    for (i = 0; i < SLOTS; i++)
                    begin
                        if (hit[i])
                        begin
                            n_seen++;
                            push_result(msot_pkg::EV_EXPIRED, i[msot_pkg::SLOT_W-1:0],
                                        n_seen == n_hit);
                        end
                    end
            end
            msot_pkg::MODE_SET:
            begin
                slot_armed[s]  = 1'b0;
                slot_period[s] = (p < min_period_q) ? min_period_q : p;
                slot_start[s]  = tick_count;
                push_result(msot_pkg::EV_DONE, '0, 1'b1);
            end
            msot_pkg::MODE_START:
            begin
                slot_start[s] = tick_count;
                slot_armed[s] = 1'b1;
                push_result(msot_pkg::EV_DONE, '0, 1'b1);
            end
            default:
            begin
                slot_armed[s] = 1'b0;
                push_result(msot_pkg::EV_DONE, '0, 1'b1);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t exp_r;
        if (!rst_n)
        begin
            min_period_q = msot_pkg::MIN_PERIOD_RST;
            tick_count   = '0;
            slot_armed   = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_start[i]  = '0;
                slot_period[i] = '0;
            end
            due_results.delete();
            due_cnt <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                    report_mismatch($sformatf("result with nothing expected: ev=%0d slot=%0d last=%0b",
                                              event_res, expired_slot, last));
                else
                begin
                    exp_r = due_results.pop_front();
                    if (event_res !== exp_r.ev)
                        report_mismatch($sformatf("event_res %0d, expected %0d",
                                                  event_res, exp_r.ev));
                    if (expired_slot !== exp_r.slot)
                        report_mismatch($sformatf("expired_slot %0d, expected %0d",
                                                  expired_slot, exp_r.slot));
                    if (last !== exp_r.last)
                        report_mismatch($sformatf("last %0b, expected %0b", last, exp_r.last));
                end
            end
            if (in_valid && in_ready)
                apply_timer_op(msot_pkg::mode_t'(mode), slot, period);
            if (cfg_wr_en)
                min_period_q = cfg_wr_data;
            due_cnt <= due_results.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for multi_slot_oneshot_timer_top: clock, reset, stimulus, config writes
// and the verdict. Depends on msot_pkg, the timer RTL and msot_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_OPS   = 76;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [msot_pkg::PERIOD_W-1:0] cfg_wr_data;
    logic                          in_valid;
    logic                          in_ready;
    logic [msot_pkg::MODE_W-1:0]   mode;
    logic [msot_pkg::SLOT_W-1:0]   slot;
    logic [msot_pkg::PERIOD_W-1:0] period;
    logic                          out_valid;
    logic                          out_ready;
    logic [msot_pkg::EV_W-1:0]     event_res;
    logic [msot_pkg::SLOT_W-1:0]   expired_slot;
    logic                          last;

    int                            mismatches;
    int                            pending_cnt;
    int                            cycle_cnt = 0;
    logic                          calm = 1'b0;
    logic                          hold_off_req = 1'b0;

    multi_slot_oneshot_timer_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .slot         (slot),
        .period       (period),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .expired_slot (expired_slot),
        .last         (last)
    );

    msot_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .slot         (slot),
        .period       (period),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .expired_slot (expired_slot),
        .last         (last),
        .mismatches   (mismatches),
        .pending_cnt  (pending_cnt)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("[multi_slot_oneshot_timer_top] ERROR");
        $finish;
    end

    // result side: random back-pressure, one long hold-off on request
    initial
    begin : receiver
        int   held;
        logic hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_done)
            begin
                out_ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_done = 1'b1;
            end
            else
                out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 26);
        end
    end

    // in_ready is sampled mid-cycle so it reflects the value at the coming edge
    task automatic send_op(input msot_pkg::mode_t m, input logic [msot_pkg::SLOT_W-1:0] s,
                           input logic [msot_pkg::PERIOD_W-1:0] p);
        logic taken;
        while (!calm && $urandom_range(0, 99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        slot     <= s;
        period   <= p;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_cnt != 0);
    endtask

    task automatic write_min_period(input logic [msot_pkg::PERIOD_W-1:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly set/start/tick sequences on one slot, the rest single random operations
    task automatic run_timer_traffic(input int n_ops);
        int                            sent;
        int                            n_ticks;
        logic [msot_pkg::SLOT_W-1:0]   s;
        logic [msot_pkg::PERIOD_W-1:0] p;
        sent = 0;
        while (sent < n_ops)
        begin
            s = msot_pkg::SLOT_W'($urandom_range(0, 15));
            if ($urandom_range(0, 99) < 60)
            begin
                p = ($urandom_range(0, 99) < 15) ? $urandom
                                                 : msot_pkg::PERIOD_W'($urandom_range(0, 15));
                send_op(msot_pkg::MODE_SET, s, p);
                send_op(msot_pkg::MODE_START, s, $urandom);
                n_ticks = $urandom_range(1, 8);
                repeat (n_ticks)
                    send_op(msot_pkg::MODE_TICK, msot_pkg::SLOT_W'($urandom_range(0, 15)),
                            $urandom);
                sent += 2 + n_ticks;
            end
            else
            begin
                send_op(msot_pkg::mode_t'($urandom_range(0, 3)), s, $urandom);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        mode        = msot_pkg::MODE_TICK;
        slot        = '0;
        period      = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset periods, clamping, restart, multiple expiries in one tick
        send_op(msot_pkg::MODE_TICK,  4'd0,  32'd0);
        send_op(msot_pkg::MODE_START, 4'd5,  32'd0);
        send_op(msot_pkg::MODE_TICK,  4'd0,  32'd0);
        send_op(msot_pkg::MODE_SET,   4'd0,  32'd0);
        send_op(msot_pkg::MODE_SET,   4'd15, 32'hFFFF_FFFF);
        send_op(msot_pkg::MODE_START, 4'd0,  32'd0);
        send_op(msot_pkg::MODE_START, 4'd15, 32'd0);
        send_op(msot_pkg::MODE_SET,   4'd3,  32'd2);
        send_op(msot_pkg::MODE_START, 4'd3,  32'd0);
        send_op(msot_pkg::MODE_STOP,  4'd15, 32'd0);
        send_op(msot_pkg::MODE_STOP,  4'd9,  32'hFFFF_FFFF);
        send_op(msot_pkg::MODE_START, 4'd1,  32'd0);
        send_op(msot_pkg::MODE_START, 4'd2,  32'd0);
        send_op(msot_pkg::MODE_START, 4'd14, 32'd0);
        send_op(msot_pkg::MODE_TICK,  4'd15, 32'hFFFF_FFFF);
        send_op(msot_pkg::MODE_START, 4'd0,  32'd0);
        repeat (10)
            send_op(msot_pkg::MODE_TICK, 4'd0, 32'd0);

        run_timer_traffic(PHASE_OPS);

        write_min_period(32'd0);
        calm = 1'b1;
        run_timer_traffic(PHASE_OPS);
        wait_drained();
        calm = 1'b0;

        write_min_period(32'hFFFF_FFFF);
        hold_off_req <= 1'b1;
        run_timer_traffic(PHASE_OPS);

        write_min_period(msot_pkg::PERIOD_W'($urandom_range(2, 6)));
        run_timer_traffic(PHASE_OPS);

        write_min_period(32'd1);
        run_timer_traffic(PHASE_OPS);

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_cnt == 0)
            $display("[multi_slot_oneshot_timer_top] OK");
        else
            $display("[multi_slot_oneshot_timer_top] ERROR");
        $finish;
    end

endmodule
